@@ sv/vgs_pkg.sv @@
// Shared types and constants of the guarded scrambler core.
package vgs_pkg;

    localparam int BYTE_W  = 8;
    localparam int HIST_W  = 12;
    localparam int COUNT_W = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DESCRAMBLE = 1'b0,
        CFG_BIS        = 1'b1
    } t_cfg_idx;

    // Operating mode, held in the top level
    typedef struct packed {
        logic descramble;
        logic bis;
    } t_cfg;

    // One result word as it waits in the output stage
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_word;

endpackage

@@ sv/vgs_in_if.sv @@
// Input channel: one byte of line bits plus end-of-block mark.
interface vgs_in_if;
    import vgs_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_in;
    logic              last_in;

    modport source (output valid, output data_in, output last_in, input ready);
    modport sink   (input valid, input data_in, input last_in, output ready);
endinterface

@@ sv/vgs_out_if.sv @@
// Output channel: one processed byte plus end-of-block mark.
interface vgs_out_if;
    import vgs_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_out;
    logic              last_out;

    modport source (output valid, output data_out, output last_out, input ready);
    modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

@@ sv/vgs_bit_cell.sv @@
// One bit lane: guard counter, inversion, 1 + x^-6 + x^-7 tap and repetition check.
module vgs_bit_cell (
    input  vgs_pkg::t_cfg                   i_cfg,
    input  logic [vgs_pkg::COUNT_W-1:0]     i_reload,
    input  logic                            i_bit,
    input  logic [vgs_pkg::HIST_W-1:0]      i_hist,
    input  logic [vgs_pkg::COUNT_W-1:0]     i_count,
    output logic                            o_bit,
    output logic [vgs_pkg::HIST_W-1:0]      o_hist,
    output logic [vgs_pkg::COUNT_W-1:0]     o_count
);
    import vgs_pkg::*;

    logic [COUNT_W-1:0] dec;
    logic               guard_hit;
    logic               scr_bit;
    logic               line;
    logic               differs;

    always_comb begin
        // guard counter steps down; at zero it reloads and flips the bit
        dec       = i_count - COUNT_W'(1);
        guard_hit = (dec == '0);
        scr_bit   = i_bit ^ guard_hit ^ i_hist[5] ^ i_hist[6];
        line      = i_cfg.descramble ? i_bit : scr_bit;

        // line bit unlike all checked history taps restarts the guard
        differs = (i_hist[8] != line) && (i_hist[11] != line)
                  && (!i_cfg.bis || (i_hist[7] != line));

        o_bit   = scr_bit;
        o_hist  = {i_hist[HIST_W-2:0], line};
        o_count = (guard_hit || differs) ? i_reload : dec;
    end
endmodule

@@ sv/vgs_out_stage.sv @@
// Output register with a skid entry so the input side can take one more word when the output stalls.
module vgs_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vgs_pkg::t_word i_word,
    output logic           o_push_ready,
    output logic           o_valid,
    output vgs_pkg::t_word o_word,
    input  logic           i_ready
);
    import vgs_pkg::*;

    logic  r_out_valid;
    logic  r_skid_valid;
    t_word r_out;
    t_word r_skid;
    logic  pop;

    assign pop          = r_out_valid && i_ready;
    assign o_push_ready = !r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_word       = r_out;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_word;
            end else begin
                r_out <= i_word;
            end
        end
    end
endmodule

@@ sv/v27_guarded_scrambler_core.sv @@
// Top level of the guarded self-synchronizing scrambler/descrambler.
// Takes one byte word per clock and returns one byte word per clock while the
// output side is ready; each accepted word is registered in the output stage.
// Eight bit lanes are chained through the 12-bit history and the 6-bit guard
// counter in a single cycle, so the rate, set by that chain, is one word per
// cycle while the output does not stall; a two-entry output stage takes one
// more word on a stall, then input ready stays low until the output takes a word.
// Bits are handled LSB first. A config write (index 0: descramble mode,
// index 1: V.27bis repetition tap) stores bit 0 of the data and restarts the
// history and guard counter; write config only while no word is in flight.
module v27_guarded_scrambler_core #(
    parameter int GUARD_LENGTH = 34
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vgs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [vgs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    vgs_in_if.sink                             i_in,
    vgs_out_if.source                          o_out
);
    import vgs_pkg::*;

    localparam logic [COUNT_W-1:0] RELOAD = COUNT_W'(GUARD_LENGTH);

    t_cfg               r_cfg;
    logic [HIST_W-1:0]  r_hist;
    logic [COUNT_W-1:0] r_count;

    logic [HIST_W-1:0]  hist_chain  [0:BYTE_W];
    logic [COUNT_W-1:0] count_chain [0:BYTE_W];
    logic [BYTE_W-1:0]  lane_bits;
    logic               accept;
    logic               push_ready;
    t_word              word_in;
    t_word              word_out;

    assign accept     = i_in.valid && push_ready;
    assign i_in.ready = push_ready;

    // bit lanes chained through history and guard counter
    assign hist_chain[0]  = r_hist;
    assign count_chain[0] = r_count;

    for (genvar g = 0; g < BYTE_W; g++) begin : g_lane
        vgs_bit_cell u_cell (
            .i_cfg    (r_cfg),
            .i_reload (RELOAD),
            .i_bit    (i_in.data_in[g]),
            .i_hist   (hist_chain[g]),
            .i_count  (count_chain[g]),
            .o_bit    (lane_bits[g]),
            .o_hist   (hist_chain[g+1]),
            .o_count  (count_chain[g+1])
        );
    end

    // merge lane outputs into one word
    assign word_in.data = lane_bits;
    assign word_in.last = i_in.last_in;

    // mode registers and scrambler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '0;
            r_hist  <= '0;
            r_count <= RELOAD;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DESCRAMBLE: r_cfg.descramble <= i_cfg_data[0];
                CFG_BIS:        r_cfg.bis        <= i_cfg_data[0];
                default:        r_cfg            <= r_cfg;
            endcase
            r_hist  <= '0;
            r_count <= RELOAD;
        end else if (accept) begin
            r_hist  <= hist_chain[BYTE_W];
            r_count <= count_chain[BYTE_W];
        end
    end

    vgs_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept),
        .i_word       (word_in),
        .o_push_ready (push_ready),
        .o_valid      (o_out.valid),
        .o_word       (word_out),
        .i_ready      (o_out.ready)
    );

    assign o_out.data_out = word_out.data;
    assign o_out.last_out = word_out.last;

    // a config write always restarts the scrambler state
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_hist == '0) && (r_count == RELOAD))
        else $error("state not restarted after config write");

    // guard counter never rests at zero
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count != '0))
        else $error("guard counter at zero");

    // input side only stalls while a word is held for the output
    a_stall_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !push_ready |-> o_out.valid)
        else $error("input stalled with no output word pending");

    // after a word is accepted, the output offers a word on the next cycle
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted word not offered");
endmodule
